// ===== design/scan_mapping_gate_defines.svh =====
// Assertion helpers for the scan mapping gate top module.
`ifndef SCAN_MAPPING_GATE_DEFINES_SVH
`define SCAN_MAPPING_GATE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define SMG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, idle while rst_ni is low.
`define SMG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/smg_pkg.sv =====
`timescale 1ns / 1ps

package smg_pkg;

  // field widths
  localparam int PoseW     = 24;
  localparam int HeadW     = 16;
  localparam int TimeW     = 32;
  localparam int PtsW      = 12;
  localparam int TransW    = 25;
  localparam int DHeadW    = 15;
  localparam int ReasonW   = 2;

  // configuration port
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;
  localparam int MaxTransW = 16;
  localparam int MaxRotW   = 15;
  localparam int SettleW   = 16;

  localparam logic [MaxTransW-1:0] MaxTransRst = MaxTransW'(350);
  localparam logic [MaxRotW-1:0]   MaxRotRst   = MaxRotW'(400);
  localparam logic [PtsW-1:0]      MinPtsRst   = PtsW'(24);
  localparam logic [SettleW-1:0]   SettleRst   = SettleW'(200);

  // datapath
  localparam int DeltaW    = PoseW + 1;          // pose step
  localparam int MulW      = DeltaW;             // shared multiplier operand
  localparam int SqW       = 2 * PoseW + 1;      // dx^2 + dy^2
  localparam int ThrW      = 2 * MaxTransW;      // max_translation^2
  localparam int RadW      = SqW + 1;            // even width for the root
  localparam int RootW     = RadW / 2;
  localparam int RemW      = RootW + 2;
  localparam int RootSteps = RootW;
  localparam int CntW      = $clog2(RootSteps);
  localparam int DhW       = HeadW + 1;
  localparam int WrapW     = DhW + 1;

  localparam int HalfTurn  = 18000;
  localparam int FullTurn  = 36000;

  typedef enum logic [ReasonW-1:0] {
    SKIP_NONE    = 2'd0,
    SKIP_TURN    = 2'd1,
    SKIP_SETTLE  = 2'd2,
    SKIP_QUALITY = 2'd3
  } skip_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_TRANS  = 2'd0,
    CFG_MAX_ROT    = 2'd1,
    CFG_MIN_PTS    = 2'd2,
    CFG_SETTLE     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_T,
    ST_ROOT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [MaxTransW-1:0] max_trans;
    logic [MaxRotW-1:0]   max_rot;
    logic [PtsW-1:0]      min_pts;
    logic [SettleW-1:0]   settle;
  } cfg_t;

  typedef struct packed {
    logic signed [PoseW-1:0] pose_x;
    logic signed [PoseW-1:0] pose_y;
    logic signed [HeadW-1:0] pose_heading;
    logic [TimeW-1:0]        time_ms;
    logic                    turn_flag;
    logic [PtsW-1:0]         usable_points;
  } frame_t;

  typedef struct packed {
    logic [TransW-1:0] delta_translation;
    logic [DHeadW-1:0] delta_heading;
    logic              turning_out;
    skip_e             skip_code;
    logic              update_allowed;
  } result_t;

  typedef struct packed {
    logic capture;
    logic sq_x;
    logic sq_y;
    logic sq_t;
    logic root_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic root_last;
  } stat_t;

endpackage

// ===== design/smg_if.sv =====
`timescale 1ns / 1ps

interface smg_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [smg_pkg::PoseW-1:0] pose_x;
  logic signed [smg_pkg::PoseW-1:0] pose_y;
  logic signed [smg_pkg::HeadW-1:0] pose_heading;
  logic [smg_pkg::TimeW-1:0]        time_ms;
  logic                             turn_flag;
  logic [smg_pkg::PtsW-1:0]         usable_points;

  modport source (output valid, pose_x, pose_y, pose_heading, time_ms, turn_flag,
                  usable_points, input ready);
  modport sink (input valid, pose_x, pose_y, pose_heading, time_ms, turn_flag,
                usable_points, output ready);
endinterface

interface smg_out_if;
  logic                        valid;
  logic                        ready;
  logic [smg_pkg::TransW-1:0]  delta_translation;
  logic [smg_pkg::DHeadW-1:0]  delta_heading;
  logic                        turning_out;
  logic [smg_pkg::ReasonW-1:0] skip_code;
  logic                        update_allowed;

  modport source (output valid, delta_translation, delta_heading, turning_out,
                  skip_code, update_allowed, input ready);
  modport sink (input valid, delta_translation, delta_heading, turning_out,
                skip_code, update_allowed, output ready);
endinterface

interface smg_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [smg_pkg::CfgIdxW-1:0]  index;
  logic [smg_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/scan_mapping_gate.sv =====
`timescale 1ns / 1ps
`include "scan_mapping_gate_defines.svh"

// Scan mapping gate: judges each lidar frame against the previous one and
// reports the pose step (floor square root of dx^2 + dy^2, 0.1 mm), the
// absolute wrapped heading change (0.01 deg) and a skip reason: turning,
// settling after a turn ends, or a quality limit. One frame is handled at a
// time and occupies the block through the accepting cycle, three passes
// through a single shared 25x25 multiplier, 25 steps of the bit-serial
// square root and the load of the output register. The result word is
// valid once that register is loaded. The frame port is ready again in the
// cycle after the load, so the next frame may enter while the previous
// result still waits to be taken; a result not yet taken when the next one
// is finished holds the block until it goes.
// Configuration writes are taken every cycle and must only be made while
// the block is idle.
module scan_mapping_gate (
  input  logic       clk_i,
  input  logic       rst_ni,
  smg_in_if.sink     frame_i,
  smg_out_if.source  result_o,
  smg_cfg_if.sink    cfg_i
);

  smg_pkg::cfg_t    cfg;
  smg_pkg::cmd_t    cmd;
  smg_pkg::stat_t   stat;
  smg_pkg::frame_t  frame;
  smg_pkg::result_t res;

  logic word_turning;
  logic word_turn_code;
  logic word_dh_ok;

  assign frame.pose_x        = frame_i.pose_x;
  assign frame.pose_y        = frame_i.pose_y;
  assign frame.pose_heading  = frame_i.pose_heading;
  assign frame.time_ms       = frame_i.time_ms;
  assign frame.turn_flag     = frame_i.turn_flag;
  assign frame.usable_points = frame_i.usable_points;

  smg_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  smg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frame_i.valid),
    .in_ready_o  (frame_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  smg_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .cfg_i    (cfg),
    .frame_i  (frame),
    .result_o (res)
  );

  assign result_o.delta_translation = res.delta_translation;
  assign result_o.delta_heading     = res.delta_heading;
  assign result_o.turning_out       = res.turning_out;
  assign result_o.skip_code         = res.skip_code;
  assign result_o.update_allowed    = res.update_allowed;

  assign word_turning   = result_o.valid && result_o.turning_out;
  assign word_turn_code = (result_o.skip_code == smg_pkg::SKIP_TURN);
  assign word_dh_ok     = (result_o.delta_heading <= smg_pkg::DHeadW'(smg_pkg::HalfTurn));

  `SMG_ASSERT_NXT(a_busy_after_accept, frame_i.valid && frame_i.ready, !frame_i.ready, "ready after take")
  `SMG_ASSERT_IMP(a_turn_reason, word_turning, word_turn_code, "turning word, other skip code")
  `SMG_ASSERT_IMP(a_heading_range, result_o.valid, word_dh_ok, "heading beyond half a turn")

endmodule

// ===== design/smg_cfg_regs.sv =====
`timescale 1ns / 1ps

module smg_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  smg_cfg_if.sink         cfg_i,
  output smg_pkg::cfg_t   cfg_o
);

  smg_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_trans <= smg_pkg::MaxTransRst;
      cfg_q.max_rot   <= smg_pkg::MaxRotRst;
      cfg_q.min_pts   <= smg_pkg::MinPtsRst;
      cfg_q.settle    <= smg_pkg::SettleRst;
    end else if (cfg_i.valid) begin
      unique case (smg_pkg::cfg_idx_e'(cfg_i.index))
        smg_pkg::CFG_MAX_TRANS: cfg_q.max_trans <= cfg_i.data[smg_pkg::MaxTransW-1:0];
        smg_pkg::CFG_MAX_ROT:   cfg_q.max_rot   <= cfg_i.data[smg_pkg::MaxRotW-1:0];
        smg_pkg::CFG_MIN_PTS:   cfg_q.min_pts   <= cfg_i.data[smg_pkg::PtsW-1:0];
        smg_pkg::CFG_SETTLE:    cfg_q.settle    <= cfg_i.data[smg_pkg::SettleW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/smg_ctrl.sv =====
`timescale 1ns / 1ps

module smg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  smg_pkg::stat_t stat_i,
  output smg_pkg::cmd_t  cmd_o
);

  smg_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      smg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = smg_pkg::ST_SQ_X;
        end
      end
      smg_pkg::ST_SQ_X: begin
        cmd_o.sq_x = 1'b1;
        state_d    = smg_pkg::ST_SQ_Y;
      end
      smg_pkg::ST_SQ_Y: begin
        cmd_o.sq_y = 1'b1;
        state_d    = smg_pkg::ST_SQ_T;
      end
      smg_pkg::ST_SQ_T: begin
        cmd_o.sq_t = 1'b1;
        state_d    = smg_pkg::ST_ROOT;
      end
      smg_pkg::ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (stat_i.root_last) begin
          state_d = smg_pkg::ST_FINISH;
        end
      end
      smg_pkg::ST_FINISH: begin
        // wait for the output register to drain
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = smg_pkg::ST_IDLE;
        end
      end
      default: state_d = smg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/smg_dp.sv =====
`timescale 1ns / 1ps

module smg_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  smg_pkg::cmd_t    cmd_i,
  output smg_pkg::stat_t   stat_o,
  input  smg_pkg::cfg_t    cfg_i,
  input  smg_pkg::frame_t  frame_i,
  output smg_pkg::result_t result_o
);

  localparam int PoseW  = smg_pkg::PoseW;
  localparam int HeadW  = smg_pkg::HeadW;
  localparam int TimeW  = smg_pkg::TimeW;
  localparam int DeltaW = smg_pkg::DeltaW;
  localparam int MulW   = smg_pkg::MulW;
  localparam int SqW    = smg_pkg::SqW;
  localparam int ThrW   = smg_pkg::ThrW;
  localparam int RadW   = smg_pkg::RadW;
  localparam int RootW  = smg_pkg::RootW;
  localparam int RemW   = smg_pkg::RemW;
  localparam int CntW   = smg_pkg::CntW;
  localparam int DhW    = smg_pkg::DhW;
  localparam int WrapW  = smg_pkg::WrapW;
  localparam int DHeadW = smg_pkg::DHeadW;

  localparam logic signed [WrapW-1:0] WrapHalf  = WrapW'(smg_pkg::HalfTurn);
  localparam logic signed [WrapW-1:0] WrapFull  = WrapW'(smg_pkg::FullTurn);
  localparam logic signed [WrapW-1:0] WrapTriH  = WrapW'(3 * smg_pkg::HalfTurn);
  localparam logic signed [WrapW-1:0] WrapTwoF  = WrapW'(2 * smg_pkg::FullTurn);

  // frame history
  logic signed [PoseW-1:0] prev_x_q, prev_y_q;
  logic signed [HeadW-1:0] prev_h_q;
  logic                    have_prev_q, prev_turn_q;
  logic [TimeW-1:0]        deadline_q;

  // per-frame working registers
  logic signed [DeltaW-1:0] dx_q, dy_q;
  logic signed [DhW-1:0]    dh_q;
  logic [TimeW-1:0]         now_q;
  logic                     turn_q, settle_q;
  logic [smg_pkg::PtsW-1:0] pts_q;
  logic [SqW-1:0]           sq_q;
  logic [ThrW-1:0]          thr_q;
  logic [DHeadW-1:0]        dhead_q;
  logic [RadW-1:0]          rad_q;
  logic [RemW-1:0]          rem_q;
  logic [RootW-1:0]         root_q;
  logic [CntW-1:0]          cnt_q;
  smg_pkg::result_t         res_q;

  logic signed [DeltaW-1:0]   dx_new, dy_new;
  logic signed [DhW-1:0]      dh_new;
  logic signed [MulW-1:0]     mul_a;
  logic signed [2*MulW-1:0]   prod;
  logic signed [WrapW-1:0]    dh_ext, dh_wrap;
  logic [DHeadW-1:0]          dh_abs;
  logic [TimeW-1:0]           left;
  logic [RemW+1:0]            rem_sh, trial;
  logic                       ge;
  logic                       fail;
  smg_pkg::skip_e             reason;

  assign dx_new = DeltaW'(frame_i.pose_x) - DeltaW'(prev_x_q);
  assign dy_new = DeltaW'(frame_i.pose_y) - DeltaW'(prev_y_q);
  assign dh_new = DhW'(frame_i.pose_heading) - DhW'(prev_h_q);

  // one shared multiplier: dx^2, dy^2, then the translation limit squared
  always_comb begin
    if (cmd_i.sq_x) begin
      mul_a = dx_q;
    end else if (cmd_i.sq_y) begin
      mul_a = dy_q;
    end else begin
      mul_a = signed'(MulW'(cfg_i.max_trans));
    end
  end
  assign prod = mul_a * mul_a;

  // heading step wrapped into [-18000, 18000]
  assign dh_ext = WrapW'(dh_q);
  always_comb begin
    priority if (dh_ext > WrapTriH) begin
      dh_wrap = dh_ext - WrapTwoF;
    end else if (dh_ext > WrapHalf) begin
      dh_wrap = dh_ext - WrapFull;
    end else if (dh_ext < -WrapTriH) begin
      dh_wrap = dh_ext + WrapTwoF;
    end else if (dh_ext < -WrapHalf) begin
      dh_wrap = dh_ext + WrapFull;
    end else begin
      dh_wrap = dh_ext;
    end
  end
  assign dh_abs = dh_wrap[WrapW-1] ? DHeadW'(-dh_wrap) : DHeadW'(dh_wrap);

  assign left = deadline_q - now_q;

  // restoring square root, one result bit per step
  assign rem_sh = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial  = (RemW+2)'({root_q, 2'b01});
  assign ge     = rem_sh >= trial;

  assign stat_o.root_last = (cnt_q == '0);

  assign fail = (sq_q > SqW'(thr_q)) || (DHeadW'(dhead_q) > DHeadW'(cfg_i.max_rot))
             || (pts_q < cfg_i.min_pts);

  always_comb begin
    priority if (turn_q) begin
      reason = smg_pkg::SKIP_TURN;
    end else if (settle_q) begin
      reason = smg_pkg::SKIP_SETTLE;
    end else if (fail) begin
      reason = smg_pkg::SKIP_QUALITY;
    end else begin
      reason = smg_pkg::SKIP_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_h_q    <= '0;
      have_prev_q <= 1'b0;
      prev_turn_q <= 1'b0;
      deadline_q  <= '0;
    end else if (cmd_i.capture) begin
      prev_x_q    <= frame_i.pose_x;
      prev_y_q    <= frame_i.pose_y;
      prev_h_q    <= frame_i.pose_heading;
      have_prev_q <= 1'b1;
      prev_turn_q <= frame_i.turn_flag;
      if (prev_turn_q && !frame_i.turn_flag) begin
        deadline_q <= frame_i.time_ms + TimeW'(cfg_i.settle);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      // first frame: zero deltas
      dx_q   <= have_prev_q ? dx_new : '0;
      dy_q   <= have_prev_q ? dy_new : '0;
      dh_q   <= have_prev_q ? dh_new : '0;
      now_q  <= frame_i.time_ms;
      turn_q <= frame_i.turn_flag;
      pts_q  <= frame_i.usable_points;
    end
    if (cmd_i.sq_x) begin
      sq_q     <= prod[SqW-1:0];
      dhead_q  <= dh_abs;
      settle_q <= !turn_q && (left != '0) && !left[TimeW-1];
    end
    if (cmd_i.sq_y) begin
      sq_q <= sq_q + prod[SqW-1:0];
    end
    if (cmd_i.sq_t) begin
      thr_q  <= prod[ThrW-1:0];
      rad_q  <= RadW'(sq_q);
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= CntW'(smg_pkg::RootSteps - 1);
    end
    if (cmd_i.root_step) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= ge ? RemW'(rem_sh - trial) : RemW'(rem_sh);
      root_q <= {root_q[RootW-2:0], ge};
      cnt_q  <= cnt_q - CntW'(1);
    end
    if (cmd_i.out_load) begin
      res_q.delta_translation <= root_q;
      res_q.delta_heading     <= dhead_q;
      res_q.turning_out       <= turn_q;
      res_q.skip_code         <= reason;
      res_q.update_allowed    <= (reason == smg_pkg::SKIP_NONE);
    end
  end

  assign result_o = res_q;

endmodule
